@@ rtl/tach_pulse_average_rpm_macros.svh @@
// Assertion macros shared by the tachometer averaging block
`ifndef TACH_PULSE_AVERAGE_RPM_MACROS_SVH
`define TACH_PULSE_AVERAGE_RPM_MACROS_SVH

// same-cycle implication
`define TPAR_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpar assertion failed");

// next-cycle implication
`define TPAR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpar assertion failed");

`endif

@@ rtl/tpar_pkg.sv @@
// Types and constants for the tachometer averaging block
package tpar_pkg;

    localparam int WIDTH_W     = 16;
    localparam int RPM_W       = 16;
    localparam int CLOCK_HZ_W  = 27;
    localparam int RPM_SCALE   = 60;
    localparam int NUM_W       = CLOCK_HZ_W + 6;
    localparam int QUOT_STEPS  = RPM_W;
    localparam int STEP_CNT_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = 27'd4000000;
    localparam logic [RPM_W-1:0]      RPM_MAX        = 16'hFFFF;

    typedef struct packed {
        logic             rpm_saturated;
        logic             zero_average;
        logic [WIDTH_W-1:0] average_width;
        logic [RPM_W-1:0]   rpm;
    } result_t;

endpackage

@@ rtl/tpar_front.sv @@
// Front end: window store, running sum and window average
module tpar_front #(
    parameter int WINDOW = 100
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tpar_pkg::WIDTH_W-1:0]  s_width,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [tpar_pkg::WIDTH_W-1:0]  push_average
);
    import tpar_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SUM_W   = WIDTH_W + SLOT_W;
    localparam int SHIFT   = SUM_W + SLOT_W;
    localparam int PROD_W  = 2 * SUM_W + 1;
    localparam logic [63:0] RECIP_ONE  = 64'd1 << SHIFT;
    localparam logic [63:0] RECIP_FULL = (RECIP_ONE + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [SUM_W:0] RECIP   = RECIP_FULL[SUM_W:0];

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_READ = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [WINDOW-1:0]   valid_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [WIDTH_W-1:0]  rd_data_reg;
    logic                old_valid_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [WIDTH_W-1:0]  window_mem [WINDOW];
    logic [WIDTH_W-1:0]  old_width;
    logic                accept;

    assign s_ready      = (state_reg == F_IDLE);
    assign accept       = s_valid && s_ready;
    assign push_valid   = (state_reg == F_PUSH);
    assign push_average = prod_reg[SHIFT +: WIDTH_W];
    assign old_width    = old_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (state_reg == F_READ) begin
            window_mem[slot_reg] <= width_reg;
        end
        if (accept) begin
            rd_data_reg <= window_mem[slot_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        sum_next   = sum_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_READ;
                end
            end
            F_READ: begin
                sum_next   = sum_reg - SUM_W'(old_width) + SUM_W'(width_reg);
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next = F_MUL;
            end
            F_MUL: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            slot_reg  <= '0;
            sum_reg   <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            sum_reg   <= sum_next;
            if (state_reg == F_READ) begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            width_reg     <= s_width;
            old_valid_reg <= valid_reg[slot_reg];
        end
        if (state_reg == F_MUL) begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end
    end

endmodule

@@ rtl/tpar_queue.sv @@
// Two-entry queue carrying window averages from front to back
module tpar_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push_valid,
    output logic                          push_ready,
    input  logic [tpar_pkg::WIDTH_W-1:0]  push_data,
    output logic                          pop_valid,
    input  logic                          pop_ready,
    output logic [tpar_pkg::WIDTH_W-1:0]  pop_data
);
    import tpar_pkg::*;

    `include "tach_pulse_average_rpm_macros.svh"

    logic [WIDTH_W-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `TPAR_ASSERT_HOLDS(a_count_bound, aclk, aresetn, 1'b1, count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    `TPAR_ASSERT_NEXT(a_pop_empties, aclk, aresetn, do_pop && !do_push && count_reg == 1, !pop_valid)

endmodule

@@ rtl/tpar_back.sv @@
// Back end: rpm division with saturation and output register
module tpar_back #(
    parameter int PRESCALE_FACTOR = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tpar_pkg::CLOCK_HZ_W-1:0] clock_hz,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  logic [tpar_pkg::WIDTH_W-1:0]    pop_average,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tpar_pkg::result_t               m_result
);
    import tpar_pkg::*;

    `include "tach_pulse_average_rpm_macros.svh"

    localparam int DEN_W = WIDTH_W + $clog2(PRESCALE_FACTOR + 1);
    localparam int HI_W  = NUM_W - QUOT_STEPS;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_LOAD  = 3'd1;
    localparam logic [2:0] B_CHECK = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_DONE  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [WIDTH_W-1:0]      avg_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [QUOT_STEPS-1:0]   low_reg;
    logic [RPM_W-1:0]        quot_reg;
    logic [STEP_CNT_W-1:0]   cnt_reg;
    logic                    zero_reg;
    logic                    sat_reg;
    logic                    m_valid_reg;
    result_t                 m_result_reg;
    logic [DEN_W-1:0]        num_hi;
    logic                    over;
    logic [DEN_W:0]          trial;
    logic                    fits;
    logic                    out_free;

    assign num_hi    = DEN_W'(num_reg[NUM_W-1 -: HI_W]);
    assign over      = (num_hi >= den_reg);
    assign trial     = {rem_reg, low_reg[QUOT_STEPS-1]};
    assign fits      = (trial >= {1'b0, den_reg});
    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = (state_reg == B_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    state_next = B_LOAD;
                end
            end
            B_LOAD: begin
                state_next = B_CHECK;
            end
            B_CHECK: begin
                state_next = (avg_reg == '0 || over) ? B_DONE : B_DIV;
            end
            B_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                avg_reg <= pop_average;
            end
            B_LOAD: begin
                num_reg <= NUM_W'(clock_hz) * NUM_W'(RPM_SCALE);
                den_reg <= DEN_W'(avg_reg) * DEN_W'(PRESCALE_FACTOR);
            end
            B_CHECK: begin
                zero_reg <= (avg_reg == '0);
                sat_reg  <= (avg_reg != '0) && over;
                rem_reg  <= num_hi;
                low_reg  <= num_reg[QUOT_STEPS-1:0];
                quot_reg <= '0;
                cnt_reg  <= STEP_CNT_W'(QUOT_STEPS - 1);
            end
            B_DIV: begin
                rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                low_reg  <= {low_reg[QUOT_STEPS-2:0], 1'b0};
                quot_reg <= {quot_reg[RPM_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            B_DONE: begin
                if (out_free) begin
                    m_result_reg.average_width <= avg_reg;
                    m_result_reg.zero_average  <= zero_reg;
                    m_result_reg.rpm_saturated <= sat_reg;
                    m_result_reg.rpm           <= zero_reg ? '0 : (sat_reg ? RPM_MAX : quot_reg);
                end
            end
            default: begin
            end
        endcase
    end

    `TPAR_ASSERT_HOLDS(a_div_den_nonzero, aclk, aresetn, state_reg == B_DIV, den_reg != '0)
    `TPAR_ASSERT_HOLDS(a_flags_exclusive, aclk, aresetn, m_valid_reg, !(m_result_reg.zero_average && m_result_reg.rpm_saturated))
    `TPAR_ASSERT_NEXT(a_pop_starts_load, aclk, aresetn, pop_valid && pop_ready, state_reg == B_LOAD)

endmodule

@@ rtl/tach_pulse_average_rpm.sv @@
// Moving-average tachometer: pulse widths in, averaged rpm out
//
// Input beats on s_t* carry one captured pulse width each. Every beat
// replaces the oldest of WINDOW stored widths and yields exactly one
// output beat on m_t*: rpm = clock_hz*60 / (PRESCALE_FACTOR*average),
// the truncated window average, and two flags in m_tuser (average zero,
// rpm clamped at 65535). clock_hz is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while no beat is in flight, as the block itself
// does not enforce this.
// The front end handles each beat by memory read, sum update, reciprocal
// multiply and hand-off, and takes no new beat until the hand-off is done.
// The back end pops an average, loads the operands, checks the range, runs
// the one-bit-per-cycle restoring divider and writes the output register;
// a zero or clamped average skips the divider. It pops no new average
// until the result has been written to the output register.
// A two-entry queue sits between the two ends, so the front keeps taking
// beats while the divider runs or the output register is stalled by
// m_tready low; s_tready drops once the queue is full.
// Reset empties the window (all widths read as zero), the sum and the
// queue, and loads clock_hz with 4000000. No clearing pass is needed.
module tach_pulse_average_rpm #(
    parameter int WINDOW          = 100,
    parameter int PRESCALE_FACTOR = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tpar_pkg::CLOCK_HZ_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] capture_width
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [15:0] rpm, [31:16] average_width
    output logic [1:0]                      m_tuser    // [0] zero_average, [1] rpm_saturated
);
    import tpar_pkg::*;

    logic [CLOCK_HZ_W-1:0] clock_hz_reg;
    logic                  push_valid, push_ready;
    logic [WIDTH_W-1:0]    push_average;
    logic                  pop_valid, pop_ready;
    logic [WIDTH_W-1:0]    pop_average;
    result_t               result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
        end else if (cfg_wr_en) begin
            clock_hz_reg <= cfg_wr_data;
        end
    end

    tpar_front #(
        .WINDOW(WINDOW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_width      (s_tdata),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_average (push_average)
    );

    tpar_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_average),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_average)
    );

    tpar_back #(
        .PRESCALE_FACTOR(PRESCALE_FACTOR)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clock_hz    (clock_hz_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_average (pop_average),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result)
    );

    assign m_tdata = {result.average_width, result.rpm};
    assign m_tuser = {result.rpm_saturated, result.zero_average};

endmodule
